### rtl/gnt_pkg.sv
package gnt_pkg;

  localparam int TOKEN_W = 32;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // bracket type 0 is the quoted string
  localparam logic [7:0] OPEN_CHARS  [4] = '{8'h22, 8'h5B, 8'h28, 8'h7B};
  localparam logic [7:0] CLOSE_CHARS [4] = '{8'h22, 8'h5D, 8'h29, 8'h7D};

  typedef enum logic [2:0] {
    KIND_SKIP    = 3'd0,
    KIND_MOVE    = 3'd1,
    KIND_WON     = 3'd2,
    KIND_DRAW    = 3'd3,
    KIND_LOST    = 3'd4,
    KIND_UNKNOWN = 3'd5,
    KIND_BAD     = 3'd6,
    KIND_END     = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE                = 4'd0,
    MODE_ONE                 = 4'd1,
    MODE_ONE_DASH            = 4'd2,
    MODE_ONE_SLASH           = 4'd3,
    MODE_HALF                = 4'd4,
    MODE_HALF_DASH           = 4'd5,
    MODE_HALF_DASH_ONE       = 4'd6,
    MODE_HALF_DASH_ONE_SLASH = 4'd7,
    MODE_ZERO                = 4'd8,
    MODE_ZERO_DASH           = 4'd9,
    MODE_MOVE                = 4'd10,
    MODE_BRACKET             = 4'd11,
    MODE_ANNOT               = 4'd12
  } mode_t;

  typedef struct packed {
    kind_t                kind;
    logic [TOKEN_W-1:0]   offset;
    logic [TOKEN_W-1:0]   length;
    logic                 done;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

### rtl/gnt_in_if.sv
interface gnt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

### rtl/gnt_out_if.sv
interface gnt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] token_offset;
  logic [31:0] token_length;
  logic        text_done;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output text_done, input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input text_done, output ready);
endinterface

### rtl/gnt_scan.sv
module gnt_scan
  import gnt_pkg::*;
#(
  parameter int OFFSET_BITS = 32,
  parameter int NEST_BITS   = 8
) (
  input  logic    clk,
  input  logic    rst,
  gnt_in_if.sink  text_in,
  input  logic    room,
  output push_t   push
);

  typedef struct packed {
    logic                   v;
    kind_t                  kind;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
  } emit_t;

  function automatic result_t to_result(emit_t e, logic done);
    result_t r;
    r.kind   = e.kind;
    r.offset = TOKEN_W'(e.off);
    r.length = TOKEN_W'(e.len);
    r.done   = done;
    return r;
  endfunction

  // input register
  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_final;
  logic                   fire;

  mode_t                  mode, mode_next;
  logic [1:0]             btype, btype_next;
  logic [NEST_BITS-1:0]   depth, depth_next;
  logic [OFFSET_BITS-1:0] start, start_next;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] posreg;

  emit_t                  mv_e;
  mode_t                  mv_mode;
  emit_t                  st_e;
  mode_t                  st_mode;
  logic                   st_set;
  logic                   st_open;
  logic [1:0]             st_type;
  emit_t                  ea, eb, ef;
  logic [7:0]             b;
  logic [1:0]             bt_open;

  assign fire          = s1_valid && room;
  assign text_in.ready = !s1_valid || fire;
  assign b             = s1_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_in.ready) begin
      s1_valid <= text_in.valid;
    end
    if (text_in.ready && text_in.valid) begin
      s1_byte  <= text_in.text_byte;
      s1_final <= text_in.final_byte;
    end
  end

  // byte inside a move, token started at start
  always_comb begin
    mv_e    = '0;
    mv_mode = MODE_MOVE;
    if (b == CH_SPACE) begin
      mv_e    = '{v: 1'b1, kind: KIND_MOVE, off: start, len: pos - start};
      mv_mode = MODE_IDLE;
    end else if (b == CH_DOT) begin
      mv_e    = '{v: 1'b1, kind: KIND_SKIP, off: start, len: pos - start + 1'b1};
      mv_mode = MODE_IDLE;
    end
  end

  // byte that starts a new token at pos
  always_comb begin
    st_e    = '0;
    st_mode = MODE_IDLE;
    st_set  = 1'b0;
    st_open = 1'b0;
    st_type = 2'd0;
    for (int t = 3; t >= 0; t--) begin
      if (b == OPEN_CHARS[t]) begin
        st_open = 1'b1;
        st_type = 2'(t);
      end
    end
    if (b != CH_SPACE) begin
      st_set = 1'b1;
      priority if (b == CH_ONE) begin
        st_mode = MODE_ONE;
      end else if (b == CH_ZERO) begin
        st_mode = MODE_ZERO;
      end else if (b == CH_STAR) begin
        st_e = '{v: 1'b1, kind: KIND_UNKNOWN, off: pos, len: OFFSET_BITS'(1)};
      end else if (st_open) begin
        st_mode = MODE_BRACKET;
      end else if (b == CH_DOLLAR) begin
        st_mode = MODE_ANNOT;
      end else if (b == CH_DOT) begin
        // a dot at token start is a one-byte skip
        st_e = '{v: 1'b1, kind: KIND_SKIP, off: pos, len: OFFSET_BITS'(1)};
      end else begin
        st_mode = MODE_MOVE;
      end
    end
  end

  assign bt_open = btype;

  always_comb begin
    mode_next  = mode;
    btype_next = btype;
    depth_next = depth;
    start_next = start;
    ea = '0;
    eb = '0;
    ef = '0;
    unique case (mode)
      MODE_ONE: begin
        if (b == CH_DASH) mode_next = MODE_ONE_DASH;
        else if (b == CH_SLASH) mode_next = MODE_ONE_SLASH;
        else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_ONE_DASH, MODE_HALF_DASH_ONE_SLASH, MODE_ZERO_DASH: begin
        if ((mode == MODE_ONE_DASH && b == CH_ZERO) ||
            (mode == MODE_HALF_DASH_ONE_SLASH && b == CH_TWO) ||
            (mode == MODE_ZERO_DASH && b == CH_ONE)) begin
          ea.v    = 1'b1;
          ea.kind = (mode == MODE_ONE_DASH) ? KIND_WON :
                    (mode == MODE_ZERO_DASH) ? KIND_LOST : KIND_DRAW;
          ea.off  = start;
          ea.len  = pos - start + 1'b1;
          mode_next = MODE_IDLE;
        end else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_ONE_SLASH: begin
        if (b == CH_TWO) mode_next = MODE_HALF;
        else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_HALF: begin
        if (b == CH_DASH) mode_next = MODE_HALF_DASH;
        else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_HALF_DASH: begin
        if (b == CH_ONE) mode_next = MODE_HALF_DASH_ONE;
        else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_HALF_DASH_ONE: begin
        if (b == CH_SLASH) mode_next = MODE_HALF_DASH_ONE_SLASH;
        else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_ZERO: begin
        if (b == CH_DASH) mode_next = MODE_ZERO_DASH;
        else begin
          ea = mv_e;
          mode_next = mv_mode;
        end
      end
      MODE_MOVE: begin
        ea = mv_e;
        mode_next = mv_mode;
      end
      MODE_ANNOT: begin
        // the byte that ends the annotation also starts the next token
        if (b < CH_ZERO || b > CH_NINE) begin
          ea = '{v: 1'b1, kind: KIND_SKIP, off: start, len: pos - start};
          eb = st_e;
          mode_next = st_mode;
          if (st_set) start_next = pos;
          if (st_open) begin
            btype_next = st_type;
            depth_next = NEST_BITS'(1);
          end
        end
      end
      MODE_BRACKET: begin
        if (btype == 2'd0) begin
          if (b == OPEN_CHARS[0]) begin
            ea = '{v: 1'b1, kind: KIND_SKIP, off: start, len: pos - start + 1'b1};
            mode_next = MODE_IDLE;
          end
        end else if (b == OPEN_CHARS[bt_open]) begin
          if (depth == {NEST_BITS{1'b1}}) begin
            ea = '{v: 1'b1, kind: KIND_BAD, off: start, len: pos - start + 1'b1};
            mode_next  = MODE_IDLE;
            depth_next = '0;
          end else begin
            depth_next = depth + 1'b1;
          end
        end else if (b == CLOSE_CHARS[bt_open]) begin
          if (depth > 1 || depth == '0) begin
            depth_next = (depth == '0) ? depth : depth - 1'b1;
          end
          if (depth <= NEST_BITS'(1)) begin
            depth_next = '0;
            ea = '{v: 1'b1, kind: KIND_SKIP, off: start, len: pos - start + 1'b1};
            mode_next = MODE_IDLE;
          end
        end
      end
      default: begin
        ea = st_e;
        mode_next = st_mode;
        if (st_set) start_next = pos;
        if (st_open) begin
          btype_next = st_type;
          depth_next = NEST_BITS'(1);
        end
      end
    endcase

    if (s1_final) begin
      ef.off = start_next;
      ef.len = pos - start_next + 1'b1;
      if (mode_next == MODE_BRACKET) begin
        ef.v = 1'b1;
        ef.kind = KIND_BAD;
      end else if (mode_next == MODE_ANNOT) begin
        ef.v = 1'b1;
        ef.kind = KIND_SKIP;
      end else if (mode_next >= MODE_ONE && mode_next <= MODE_MOVE) begin
        ef.v = 1'b1;
        ef.kind = KIND_MOVE;
      end else if (!ea.v) begin
        ef = '{v: 1'b1, kind: KIND_END, off: pos + 1'b1, len: '0};
      end
    end
  end

  // pack up to two results in order, the final flag on the last one
  always_comb begin
    push = '0;
    if (fire) begin
      if (ea.v) begin
        push.v0 = 1'b1;
        push.r0 = to_result(ea, s1_final && !(eb.v || ef.v));
        if (eb.v) begin
          push.v1 = 1'b1;
          push.r1 = to_result(eb, s1_final);
        end else if (ef.v) begin
          push.v1 = 1'b1;
          push.r1 = to_result(ef, s1_final);
        end
      end else if (ef.v) begin
        push.v0 = 1'b1;
        push.r0 = to_result(ef, s1_final);
      end
    end
  end

  assign pos = posreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      btype  <= 2'd0;
      depth  <= '0;
      start  <= '0;
      posreg <= '0;
    end else if (fire) begin
      if (s1_final) begin
        mode   <= MODE_IDLE;
        btype  <= 2'd0;
        depth  <= '0;
        start  <= '0;
        posreg <= '0;
      end else begin
        mode   <= mode_next;
        btype  <= btype_next;
        depth  <= depth_next;
        start  <= start_next;
        posreg <= posreg + 1'b1;
      end
    end
  end

endmodule

### rtl/gnt_rq.sv
module gnt_rq
  import gnt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      room,
  gnt_out_if.source token_out
);

  result_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr1, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic [QCNT_W-1:0] n_push;
  logic              pop;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign pop     = token_out.valid && token_out.ready;
  assign n_push  = QCNT_W'(push.v0) + QCNT_W'(push.v1);
  assign count_next = count + n_push - QCNT_W'(pop);
  // two free entries cover the most one item can cause
  assign room    = count <= QCNT_W'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr] <= push.r0;
    if (push.v1) mem[wr_ptr1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  assign token_out.valid        = count != '0;
  assign token_out.token_kind   = mem[rd_ptr].kind;
  assign token_out.token_offset = mem[rd_ptr].offset;
  assign token_out.token_length = mem[rd_ptr].length;
  assign token_out.text_done    = mem[rd_ptr].done;

endmodule

### rtl/game_notation_tokenizer.sv
// game-notation tokenizer
// text_in carries one text byte per item with final_byte set on the last byte
// of a text; token_out carries one token per item: kind, start offset, length
// and text_done on the last token caused by the final byte.
// a byte lands in an input register and is scanned there; its tokens (zero,
// one or two) are written to a four-entry result queue whose head drives
// token_out, so a token is valid on token_out once its byte has passed the
// input register and has been written into the queue.
// one byte is taken per cycle while the queue has two free entries; a byte
// that ends an annotation and starts a one-byte token, or a final byte, can
// cause two tokens, and the single output drains one per cycle when ready.
// when the receiver stalls the queue fills and text_in.ready drops; nothing
// is dropped. reset empties the queue and returns the scanner to offset 0
// between tokens; after each final byte the scanner returns to that state.
// offsets wrap at 2**OFFSET_BITS; comments nest up to 2**NEST_BITS-1 levels.
module game_notation_tokenizer
  import gnt_pkg::*;
#(
  parameter int OFFSET_BITS = 32,
  parameter int NEST_BITS   = 8
) (
  input  logic      clk,
  input  logic      rst,
  gnt_in_if.sink    text_in,
  gnt_out_if.source token_out
);

  push_t push;
  logic  room;

  gnt_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .NEST_BITS   (NEST_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .room    (room),
    .push    (push)
  );

  gnt_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .token_out (token_out)
  );

endmodule

### tb/game_notation_tokenizer_tb.sv
`timescale 1ns / 100ps

module game_notation_tokenizer_tb;
  import gnt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1660;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam logic [7:0] NEST_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
    logic       typed;
    result_t    want;
  } stim_t;

  // typed rows carry their token; the rest go through the scanner model
  localparam int N_ROWS = 25;
  localparam stim_t ROWS [N_ROWS] = '{
    '{CH_STAR,   1'b0, 1'b1, '{KIND_UNKNOWN, 32'd0, 32'd1, 1'b0}},
    '{CH_ONE,    1'b0, 1'b0, '0},
    '{CH_DASH,   1'b0, 1'b0, '0},
    '{CH_ZERO,   1'b0, 1'b0, '0},
    '{CH_ONE,    1'b0, 1'b0, '0},
    '{CH_SLASH,  1'b0, 1'b0, '0},
    '{CH_TWO,    1'b0, 1'b0, '0},
    '{CH_DASH,   1'b0, 1'b0, '0},
    '{CH_ONE,    1'b0, 1'b0, '0},
    '{CH_SLASH,  1'b0, 1'b0, '0},
    '{CH_TWO,    1'b0, 1'b0, '0},
    '{CH_ZERO,   1'b0, 1'b0, '0},
    '{CH_DASH,   1'b0, 1'b0, '0},
    '{CH_ONE,    1'b0, 1'b0, '0},
    // annotation closed by a star: two tokens from one byte
    '{CH_DOLLAR, 1'b0, 1'b0, '0},
    '{CH_STAR,   1'b0, 1'b0, '0},
    '{CH_DOT,    1'b0, 1'b0, '0},
    '{"(",       1'b1, 1'b1, '{KIND_BAD, 32'd17, 32'd1, 1'b1}},
    '{8'hFF,     1'b0, 1'b0, '0},
    '{8'h00,     1'b0, 1'b0, '0},
    '{CH_DOT,    1'b0, 1'b0, '0},
    '{CH_ZERO,   1'b0, 1'b0, '0},
    '{CH_SLASH,  1'b0, 1'b0, '0},
    '{CH_SPACE,  1'b1, 1'b0, '0},
    '{CH_SPACE,  1'b1, 1'b1, '{KIND_END, 32'd1, 32'd0, 1'b1}}
  };

  localparam string MARKS [4] = '{"1-0", "1/2-1/2", "0-1", "*"};
  localparam string MOVE_HEAD = "abcdefghNBRQKO";
  localparam string MOVE_BODY = "abcdefgh12345678x+#=";

  logic clk;
  logic rst;

  gnt_in_if  text_in();
  gnt_out_if token_out();

  game_notation_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .token_out (token_out)
  );

  stim_t      feed_q [$];
  stim_t      on_wire;
  result_t    due_tokens [$];
  result_t    step_tokens [$];
  logic [7:0] draft_text [$];

  // scanner model state
  mode_t       scan_mode;
  logic [1:0]  brk_kind;
  logic [7:0]  depth;
  logic [31:0] tok_start;
  logic [31:0] byte_pos;

  int errors;
  int cycles;
  int sent_bytes;
  int texts;
  int hold_req;
  int hold_seen;
  int hold_left;
  bit steady;

  always #2 clk = ~clk;

  task automatic reset_scanner();
    scan_mode = MODE_IDLE;
    brk_kind  = 2'd0;
    depth     = 8'd0;
    tok_start = 32'd0;
    byte_pos  = 32'd0;
  endtask

  task automatic add_token(kind_t kind, logic [31:0] off, logic [31:0] len);
    result_t r;
    r.kind   = kind;
    r.offset = off;
    r.length = len;
    r.done   = 1'b0;
    step_tokens.push_back(r);
  endtask

  task automatic move_char(logic [7:0] b, logic [31:0] pos);
    if (b == CH_SPACE) begin
      add_token(KIND_MOVE, tok_start, pos - tok_start);
      scan_mode = MODE_IDLE;
    end else if (b == CH_DOT) begin
      // move number, skipped along with its dot
      add_token(KIND_SKIP, tok_start, pos - tok_start + 32'd1);
      scan_mode = MODE_IDLE;
    end else begin
      scan_mode = MODE_MOVE;
    end
  endtask

  task automatic open_token(logic [7:0] b, logic [31:0] pos);
    int found;
    found = -1;
    scan_mode = MODE_IDLE;
    for (int t = 0; t < 4; t++)
      if (found < 0 && b == OPEN_CHARS[t]) found = t;
    if (b != CH_SPACE) begin
      tok_start = pos;
      if (b == CH_ONE) scan_mode = MODE_ONE;
      else if (b == CH_ZERO) scan_mode = MODE_ZERO;
      else if (b == CH_STAR) add_token(KIND_UNKNOWN, pos, 32'd1);
      else if (found >= 0) begin
        scan_mode = MODE_BRACKET;
        brk_kind  = found[1:0];
        depth     = 8'd1;
      end else if (b == CH_DOLLAR) scan_mode = MODE_ANNOT;
      else move_char(b, pos);
    end
  endtask

  task automatic mark_next(logic [7:0] b, logic [7:0] want, mode_t nxt, logic [31:0] pos);
    if (b == want) scan_mode = nxt;
    else move_char(b, pos);
  endtask

  task automatic mark_end(logic [7:0] b, logic [7:0] want, kind_t kind, logic [31:0] pos);
    if (b == want) begin
      add_token(kind, tok_start, pos - tok_start + 32'd1);
      scan_mode = MODE_IDLE;
    end else begin
      move_char(b, pos);
    end
  endtask

  // tokens caused by one byte land in step_tokens
  task automatic scan_byte(logic [7:0] b, logic fin);
    logic [31:0] pos;
    logic [1:0]  t;
    result_t     last;
    pos = byte_pos;
    t   = brk_kind;
    case (scan_mode)
      MODE_ONE: begin
        if (b == CH_DASH) scan_mode = MODE_ONE_DASH;
        else if (b == CH_SLASH) scan_mode = MODE_ONE_SLASH;
        else move_char(b, pos);
      end
      MODE_ONE_DASH:            mark_end(b, CH_ZERO, KIND_WON, pos);
      MODE_ONE_SLASH:           mark_next(b, CH_TWO, MODE_HALF, pos);
      MODE_HALF:                mark_next(b, CH_DASH, MODE_HALF_DASH, pos);
      MODE_HALF_DASH:           mark_next(b, CH_ONE, MODE_HALF_DASH_ONE, pos);
      MODE_HALF_DASH_ONE:       mark_next(b, CH_SLASH, MODE_HALF_DASH_ONE_SLASH, pos);
      MODE_HALF_DASH_ONE_SLASH: mark_end(b, CH_TWO, KIND_DRAW, pos);
      MODE_ZERO:                mark_next(b, CH_DASH, MODE_ZERO_DASH, pos);
      MODE_ZERO_DASH:           mark_end(b, CH_ONE, KIND_LOST, pos);
      MODE_MOVE:                move_char(b, pos);
      MODE_ANNOT: begin
        // the non-digit closes the annotation and starts the next token
        if (b < CH_ZERO || b > CH_NINE) begin
          add_token(KIND_SKIP, tok_start, pos - tok_start);
          open_token(b, pos);
        end
      end
      MODE_BRACKET: begin
        if (t == 2'd0) begin
          if (b == CLOSE_CHARS[0]) begin
            add_token(KIND_SKIP, tok_start, pos - tok_start + 32'd1);
            scan_mode = MODE_IDLE;
          end
        end else if (b == OPEN_CHARS[t]) begin
          if (depth >= NEST_MAX) begin
            add_token(KIND_BAD, tok_start, pos - tok_start + 32'd1);
            scan_mode = MODE_IDLE;
            depth = 8'd0;
          end else begin
            depth = depth + 8'd1;
          end
        end else if (b == CLOSE_CHARS[t]) begin
          if (depth > 8'd0) depth = depth - 8'd1;
          if (depth == 8'd0) begin
            add_token(KIND_SKIP, tok_start, pos - tok_start + 32'd1);
            scan_mode = MODE_IDLE;
          end
        end
      end
      default: open_token(b, pos);
    endcase
    byte_pos = pos + 32'd1;
    if (fin) begin
      if (scan_mode == MODE_BRACKET)
        add_token(KIND_BAD, tok_start, pos - tok_start + 32'd1);
      else if (scan_mode == MODE_ANNOT)
        add_token(KIND_SKIP, tok_start, pos - tok_start + 32'd1);
      else if (scan_mode >= MODE_ONE && scan_mode <= MODE_MOVE)
        add_token(KIND_MOVE, tok_start, pos - tok_start + 32'd1);
      else if (step_tokens.size() == 0)
        add_token(KIND_END, byte_pos, 32'd0);
      last = step_tokens.pop_back();
      last.done = 1'b1;
      step_tokens.push_back(last);
      reset_scanner();
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: token %s mismatch, expected %0d actual %0d", $time, name, exp, act);
    end
  endfunction

  // sender
  always @(posedge clk) begin : drive
    stim_t nxt;
    if (rst) begin
      text_in.valid <= 1'b0;
    end else if (!text_in.valid || text_in.ready) begin
      if (feed_q.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
        nxt = feed_q.pop_front();
        on_wire            <= nxt;
        text_in.valid      <= 1'b1;
        text_in.text_byte  <= nxt.text_byte;
        text_in.final_byte <= nxt.final_byte;
      end else begin
        text_in.valid <= 1'b0;
      end
    end
  end

  // receiver, with a single long hold-off
  always @(posedge clk) begin
    if (rst) begin
      token_out.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen       <= hold_req;
      hold_left       <= HOLD_CYCLES;
      token_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      token_out.ready <= 1'b0;
    end else begin
      token_out.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // check delivered tokens, then predict the tokens of the item taken now
  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    if (!rst) begin
      if (token_out.valid && token_out.ready) begin
        got.kind   = kind_t'(token_out.token_kind);
        got.offset = token_out.token_offset;
        got.length = token_out.token_length;
        got.done   = token_out.text_done;
        if (due_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected token, expected none, actual kind %0d offset %0d length %0d done %0b",
                   $time, got.kind, got.offset, got.length, got.done);
        end else begin
          want = due_tokens.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("offset", want.offset, got.offset);
          check_field("length", want.length, got.length);
          check_field("done", 32'(want.done), 32'(got.done));
        end
      end
      if (text_in.valid && text_in.ready) begin
        step_tokens.delete();
        scan_byte(text_in.text_byte, text_in.final_byte);
        if (on_wire.typed) due_tokens.push_back(on_wire.want);
        else foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_text();
    stim_t s;
    foreach (draft_text[i]) begin
      s = '0;
      s.text_byte  = draft_text[i];
      s.final_byte = (i == draft_text.size() - 1);
      feed_q.push_back(s);
    end
    sent_bytes += draft_text.size();
    draft_text.delete();
  endtask

  task automatic wait_drained();
    while (feed_q.size() > 0 || text_in.valid || due_tokens.size() > 0) @(negedge clk);
  endtask

  function automatic logic [7:0] comment_byte(int t);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == OPEN_CHARS[t] || b == CLOSE_CHARS[t]);
    return b;
  endfunction

  task automatic add_comment(bit last);
    int t;
    int lvl;
    int n;
    int r;
    t   = $urandom_range(0, 3);
    lvl = 1;
    n   = $urandom_range(0, 10);
    draft_text.push_back(OPEN_CHARS[t]);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (t != 0 && r < 20 && lvl < 6) begin
        draft_text.push_back(OPEN_CHARS[t]);
        lvl++;
      end else if (t != 0 && r < 35 && lvl > 1) begin
        draft_text.push_back(CLOSE_CHARS[t]);
        lvl--;
      end else begin
        draft_text.push_back(comment_byte(t));
      end
    end
    // sometimes leave the comment open at the end of text
    if (!(last && $urandom_range(0, 4) == 0))
      repeat (t == 0 ? 1 : lvl) draft_text.push_back(CLOSE_CHARS[t]);
  endtask

  task automatic add_piece(bit last);
    int r;
    int m;
    int n;
    r = $urandom_range(0, 99);
    m = $urandom_range(0, 3);
    if (r < 30) begin
      draft_text.push_back(MOVE_HEAD[$urandom_range(0, MOVE_HEAD.len() - 1)]);
      repeat ($urandom_range(0, 4))
        draft_text.push_back(MOVE_BODY[$urandom_range(0, MOVE_BODY.len() - 1)]);
    end else if (r < 40) begin
      repeat ($urandom_range(1, 3)) draft_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      repeat ($urandom_range(1, 3)) draft_text.push_back(CH_DOT);
    end else if (r < 55) begin
      for (int j = 0; j < MARKS[m].len(); j++) draft_text.push_back(MARKS[m][j]);
    end else if (r < 63) begin
      // prefix of a result mark broken by an arbitrary byte
      m = $urandom_range(0, 2);
      n = $urandom_range(1, MARKS[m].len() - 1);
      for (int j = 0; j < n; j++) draft_text.push_back(MARKS[m][j]);
      draft_text.push_back(8'($urandom_range(0, 255)));
    end else if (r < 73) begin
      draft_text.push_back(CH_DOLLAR);
      repeat ($urandom_range(0, 3)) draft_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end else if (r < 88) begin
      add_comment(last);
    end else begin
      repeat ($urandom_range(1, 3)) draft_text.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_text();
    int n;
    int r;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      add_piece(k == n - 1);
      r = $urandom_range(0, 9);
      if (k == n - 1 && r < 5) r = 0;
      if (r >= 2) draft_text.push_back(CH_SPACE);
      if (r >= 8) draft_text.push_back(CH_SPACE);
    end
    send_text();
  endtask

  // comment nested to the counter limit, optionally one level past it
  task automatic build_deep_text(bit overflow);
    int t;
    t = $urandom_range(1, 3);
    repeat (int'(NEST_MAX) + (overflow ? 1 : 0)) draft_text.push_back(OPEN_CHARS[t]);
    if (overflow) begin
      draft_text.push_back(CH_SPACE);
      draft_text.push_back("e");
      draft_text.push_back("4");
    end else begin
      draft_text.push_back("z");
      repeat (int'(NEST_MAX)) draft_text.push_back(CLOSE_CHARS[t]);
      for (int j = 0; j < MARKS[0].len(); j++) draft_text.push_back(MARKS[0][j]);
    end
    send_text();
  endtask

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    text_in.valid        = 1'b0;
    text_in.text_byte    = 8'h00;
    text_in.final_byte   = 1'b0;
    token_out.ready      = 1'b0;
    on_wire              = '0;
    errors               = 0;
    cycles               = 0;
    sent_bytes           = 0;
    texts                = 0;
    hold_req             = 0;
    hold_seen            = 0;
    hold_left            = 0;
    steady               = 1'b0;
    reset_scanner();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (ROWS[i]) feed_q.push_back(ROWS[i]);
    wait_drained();

    while (sent_bytes < RANDOM_BYTES) begin
      @(negedge clk);
      texts++;
      if (texts == 6) begin
        // no idling while the receiver holds off: the block has to back up
        steady = 1'b1;
        hold_req++;
      end
      if (texts == 30) steady = 1'b0;
      if (texts % 15 == 0) wait_drained();
      if (texts == 3) build_deep_text(1'b1);
      else if (texts == 20) build_deep_text(1'b0);
      else build_text();
      while (feed_q.size() > 40) @(negedge clk);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && due_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
